// File: rtl/afd_pkg.sv
// Shared types, codes and helpers for the frame deframer.
`default_nettype none

package afd_pkg;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] GOOD_SUM   = 8'hFF;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_TX_STATUS   = 2'd0;
    localparam logic [1:0] REG_RX_PACKET   = 2'd1;
    localparam logic [1:0] REG_AT_RESPONSE = 2'd2;

    localparam logic [7:0] RST_TX_STATUS   = 8'd139;
    localparam logic [7:0] RST_RX_PACKET   = 8'd144;
    localparam logic [7:0] RST_AT_RESPONSE = 8'd136;

    // Frame kinds
    localparam logic [1:0] KIND_TX_STATUS   = 2'd0;
    localparam logic [1:0] KIND_RX_PACKET   = 2'd1;
    localparam logic [1:0] KIND_AT_RESPONSE = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN     = 2'd3;

    // Frame status on frame end
    localparam logic [1:0] STAT_GOOD   = 2'd0;
    localparam logic [1:0] STAT_BADSUM = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_BODY   = 3'd3,
        PH_CHECK  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] tx_status_type;
        logic [7:0] rx_packet_type;
        logic [7:0] at_response_type;
    } t_cfg;

    typedef struct packed {
        logic       is_end;
        logic [7:0] data_byte;
        logic [7:0] frame_type;
        logic [1:0] frame_kind;
        logic [1:0] frame_status;
    } t_result;

    // tx status beats rx packet beats AT response when codes coincide
    function automatic logic [1:0] kind_of(input t_cfg cfg, input logic [7:0] ftype);
        logic [1:0] kind;
        if (ftype == cfg.tx_status_type) begin
            kind = KIND_TX_STATUS;
        end else if (ftype == cfg.rx_packet_type) begin
            kind = KIND_RX_PACKET;
        end else if (ftype == cfg.at_response_type) begin
            kind = KIND_AT_RESPONSE;
        end else begin
            kind = KIND_UNKNOWN;
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

// File: rtl/afd_apb_regs.sv
// APB configuration registers holding the frame type codes.
`default_nettype none

module afd_apb_regs
    import afd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tx_status_type   <= RST_TX_STATUS;
            r_cfg.rx_packet_type   <= RST_RX_PACKET;
            r_cfg.at_response_type <= RST_AT_RESPONSE;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_TX_STATUS:   r_cfg.tx_status_type   <= pwdata[7:0];
                REG_RX_PACKET:   r_cfg.rx_packet_type   <= pwdata[7:0];
                REG_AT_RESPONSE: r_cfg.at_response_type <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TX_STATUS:   prdata = {24'd0, r_cfg.tx_status_type};
            REG_RX_PACKET:   prdata = {24'd0, r_cfg.rx_packet_type};
            REG_AT_RESPONSE: prdata = {24'd0, r_cfg.at_response_type};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/afd_parser.sv
// Frame parser: input register, frame state machine and result register.
`default_nettype none

module afd_parser
    import afd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_result         o_result
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_phase      r_phase,   n_phase;
    logic [15:0] r_len,     n_len;
    logic [15:0] r_seen,    n_seen;
    logic [7:0]  r_sum,     n_sum;
    logic [7:0]  r_held,    n_held;
    logic        r_out_valid;
    t_result     r_out;

    t_result     w_res;
    logic        w_res_valid;
    logic        w_out_ready;
    logic        w_step;
    logic [15:0] w_len_full;
    logic [15:0] w_seen_inc;
    logic [7:0]  w_sum_inc;

    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_step      = r_in_valid && w_out_ready;
    assign o_in_stall  = r_in_valid && !w_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    assign w_len_full = {r_len[15:8], r_in_byte};
    assign w_seen_inc = r_seen + 16'd1;
    assign w_sum_inc  = r_sum + r_in_byte;

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_seen      = r_seen;
        n_sum       = r_sum;
        n_held      = r_held;
        w_res       = '0;
        w_res_valid = 1'b0;
        unique case (r_phase)
            PH_LEN_HI: begin
                n_len   = {r_in_byte, 8'h00};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len  = w_len_full;
                n_seen = 16'd0;
                n_sum  = 8'd0;
                n_held = 8'd0;
                if (w_len_full == 16'd0) begin
                    // empty frame ends here, no type or checksum byte follows
                    n_phase            = PH_HUNT;
                    w_res_valid        = 1'b1;
                    w_res.is_end       = 1'b1;
                    w_res.frame_kind   = KIND_UNKNOWN;
                    w_res.frame_status = STAT_EMPTY;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_sum  = w_sum_inc;
                n_seen = w_seen_inc;
                if (w_seen_inc >= r_len) begin
                    n_phase = PH_CHECK;
                end
                if (w_seen_inc == 16'd1) begin
                    n_held = r_in_byte;
                end else begin
                    w_res_valid      = 1'b1;
                    w_res.data_byte  = r_in_byte;
                    w_res.frame_type = r_held;
                    w_res.frame_kind = kind_of(i_cfg, r_held);
                end
            end
            PH_CHECK: begin
                n_sum              = w_sum_inc;
                n_phase            = PH_HUNT;
                w_res_valid        = 1'b1;
                w_res.is_end       = 1'b1;
                w_res.frame_type   = r_held;
                w_res.frame_kind   = kind_of(i_cfg, r_held);
                w_res.frame_status = (w_sum_inc == GOOD_SUM) ? STAT_GOOD : STAT_BADSUM;
            end
            default: begin
                n_phase = (r_in_byte == START_BYTE) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= 16'd0;
            r_seen  <= 16'd0;
            r_sum   <= 8'd0;
            r_held  <= 8'd0;
        end else if (w_step) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_step && w_res_valid;
        end
        if (w_out_ready) begin
            r_out <= w_res;
        end
    end

endmodule

`default_nettype wire

// File: rtl/api_frame_deframer_top.sv
// Top level of the delimiter/length/checksum frame deframer.
//
// Input channel: one received serial byte per item (i_in_valid / o_in_stall).
// The block hunts for the 0x7E start byte, reads a big-endian 16-bit length,
// the type byte, the payload and a checksum byte. Each payload byte leaves as
// a data item; the checksum byte gives a frame-end item with type, kind and
// status (good, checksum error); a zero length gives one with empty status.
// Bytes that give no result, such as the type byte, are consumed silently.
// Output channel: o_out_valid / i_out_stall with one port per result field.
// A result passes through one input register and one result register with
// the parser logic between them. One item per cycle is taken while the
// output does not stall; a stalled result holds, and the input keeps flowing
// into the input register until that is also full, then o_in_stall rises.
// APB writes set the three type codes; write them only while the block idles.
// Synchronous reset clears both registers' valid flags and returns the parser
// to hunting, with the type codes at 139, 144 and 136.
`default_nettype none

module api_frame_deframer_top
    import afd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_is_end,
    output logic      [7:0]  o_data_byte,
    output logic      [7:0]  o_frame_type,
    output logic      [1:0]  o_frame_kind,
    output logic      [1:0]  o_frame_status
);

    t_cfg    w_cfg;
    t_result w_result;

    afd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    afd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_result)
    );

    assign o_is_end       = w_result.is_end;
    assign o_data_byte    = w_result.data_byte;
    assign o_frame_type   = w_result.frame_type;
    assign o_frame_kind   = w_result.frame_kind;
    assign o_frame_status = w_result.frame_status;

endmodule

`default_nettype wire
